### sv/rau_pkg.sv
// shared types and constants for the rational arithmetic unit
`timescale 1ns / 1ps
package rau_pkg;
    localparam int WIDTH = 32;
    localparam int DW    = 64;

    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_SUB = 2'd1;
    localparam logic [1:0] MODE_MUL = 2'd2;
    localparam logic [1:0] MODE_DIV = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef logic [DW-1:0] t_word;

    // start request to an iterative unit with its two operands
    typedef struct packed {
        logic  start;
        t_word a;
        t_word b;
    } t_unit_req;

    typedef struct packed {
        logic  done;
        t_word value;
    } t_unit_rsp;
endpackage

### sv/rau_if.sv
// request and result channel interfaces
`timescale 1ns / 1ps
interface rau_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic signed [31:0] first_num;
    logic [30:0]        first_den;
    logic signed [31:0] second_num;
    logic [30:0]        second_den;
    modport source(output valid, mode, first_num, first_den, second_num, second_den,
                   input ready);
    modport sink(input valid, mode, first_num, first_den, second_num, second_den,
                 output ready);
endinterface

interface rau_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_num;
    logic [30:0]        result_den;
    logic [1:0]         status;
    modport source(output valid, result_num, result_den, status, input ready);
    modport sink(input valid, result_num, result_den, status, output ready);
endinterface

### sv/rational_arithmetic_unit.sv
// top level: sequencer, shared multiplier, gcd and divider units
//  channel | dir | handshake     | payload
//  i_req   | in  | valid / ready | mode, first_num/den, second_num/den
//  o_res   | out | valid / ready | result_num, result_den, status
// the divider runs four passes for add and subtract and two for multiply and divide,
// and the gcd runs two passes for add and subtract and one for multiply and divide,
// so the divider and gcd loops set the time of a request
// a zero operand denominator goes straight from idle to the output state
// reset is synchronous, active low, and clears the sequencer state and the output valid flag
// the block takes a new request only when idle; a stalled result holds in
// the output register while the next request runs
`timescale 1ns / 1ps
module rational_arithmetic_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rau_req_if.sink    i_req,
    rau_res_if.source  o_res
);
    import rau_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_G1_GO = 5'd1;
    localparam logic [4:0] S_G1_WT = 5'd2;
    localparam logic [4:0] S_DA_GO = 5'd3;
    localparam logic [4:0] S_DA_WT = 5'd4;
    localparam logic [4:0] S_DB_GO = 5'd5;
    localparam logic [4:0] S_DB_WT = 5'd6;
    localparam logic [4:0] S_LCM   = 5'd7;
    localparam logic [4:0] S_T1    = 5'd8;
    localparam logic [4:0] S_T2    = 5'd9;
    localparam logic [4:0] S_SUM   = 5'd10;
    localparam logic [4:0] S_P1    = 5'd11;
    localparam logic [4:0] S_P2    = 5'd12;
    localparam logic [4:0] S_P3    = 5'd13;
    localparam logic [4:0] S_NORM  = 5'd14;
    localparam logic [4:0] S_G2_GO = 5'd15;
    localparam logic [4:0] S_G2_WT = 5'd16;
    localparam logic [4:0] S_DN_GO = 5'd17;
    localparam logic [4:0] S_DN_WT = 5'd18;
    localparam logic [4:0] S_DD_GO = 5'd19;
    localparam logic [4:0] S_DD_WT = 5'd20;
    localparam logic [4:0] S_CHK   = 5'd21;
    localparam logic [4:0] S_OUT   = 5'd22;

    localparam logic signed [DW-1:0] LIM = DW'(64'sd1 <<< (WIDTH - 1));

    logic [4:0]          r_state;
    logic [1:0]          r_mode;
    logic signed [31:0]  r_n1, r_n2;
    logic [30:0]         r_d1, r_d2, r_a, r_b;
    logic signed [DW-1:0] r_num, r_den, r_prod;
    t_word               r_g;
    logic                r_neg;
    logic [1:0]          r_stat;
    logic                r_ov;
    logic signed [31:0]  r_rnum;
    logic [30:0]         r_rden;
    logic [1:0]          r_rst;

    logic signed [32:0]  w_ma, w_mb;
    logic signed [65:0]  w_full;
    t_unit_req           w_greq, w_dreq;
    t_unit_rsp           w_grsp, w_drsp;
    t_word               w_mag;
    logic                w_load;

    assign w_mag  = r_num[DW-1] ? t_word'(-r_num) : t_word'(r_num);
    assign w_load = (r_state == S_OUT) && (!r_ov || o_res.ready);

    // shared multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_LCM: begin w_ma = {2'b00, r_a}; w_mb = {2'b00, r_d2}; end
            S_T1:  begin w_ma = {r_n1[31], r_n1}; w_mb = {2'b00, r_b}; end
            S_T2:  begin w_ma = {r_n2[31], r_n2}; w_mb = {2'b00, r_a}; end
            S_P1: begin
                w_ma = {r_n1[31], r_n1};
                w_mb = (r_mode == MODE_MUL) ? {r_n2[31], r_n2} : {2'b00, r_d2};
            end
            S_P2: begin
                w_ma = {2'b00, r_d1};
                w_mb = (r_mode == MODE_MUL) ? {2'b00, r_d2} : {r_n2[31], r_n2};
            end
            default: ;
        endcase
    end
    assign w_full = w_ma * w_mb;

    always_comb begin
        w_greq.start = 1'b0;
        w_greq.a     = w_mag;
        w_greq.b     = t_word'(r_den);
        w_dreq.start = 1'b0;
        w_dreq.a     = w_mag;
        w_dreq.b     = r_g;
        case (r_state)
            S_G1_GO: begin
                w_greq.start = 1'b1;
                w_greq.a     = t_word'(r_d1);
                w_greq.b     = t_word'(r_d2);
            end
            S_G2_GO: w_greq.start = 1'b1;
            S_DA_GO: begin w_dreq.start = 1'b1; w_dreq.a = t_word'(r_d1); end
            S_DB_GO: begin w_dreq.start = 1'b1; w_dreq.a = t_word'(r_d2); end
            S_DN_GO: w_dreq.start = 1'b1;
            S_DD_GO: begin w_dreq.start = 1'b1; w_dreq.a = t_word'(r_den); end
            default: ;
        endcase
    end

    rau_gcd u_gcd (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_greq), .o_rsp(w_grsp));
    rau_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq), .o_rsp(w_drsp));

    always_ff @(posedge i_clk) begin
        r_prod <= w_full[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            if (r_ov && o_res.ready && !w_load) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_mode <= i_req.mode;
                        r_n1   <= i_req.first_num;
                        r_d1   <= i_req.first_den;
                        r_n2   <= i_req.second_num;
                        r_d2   <= i_req.second_den;
                        r_stat <= (i_req.first_den == '0 || i_req.second_den == '0)
                                  ? ST_ZERO_DEN : ST_OK;
                        if (i_req.first_den == '0 || i_req.second_den == '0) begin
                            r_state <= S_OUT;
                        end else if (i_req.mode == MODE_ADD || i_req.mode == MODE_SUB) begin
                            r_state <= S_G1_GO;
                        end else begin
                            r_state <= S_P1;
                        end
                    end
                end
                S_G1_GO: r_state <= S_G1_WT;
                S_G1_WT: begin
                    if (w_grsp.done) begin
                        r_g     <= w_grsp.value;
                        r_state <= S_DA_GO;
                    end
                end
                S_DA_GO: r_state <= S_DA_WT;
                S_DA_WT: begin
                    if (w_drsp.done) begin
                        r_a     <= w_drsp.value[30:0];
                        r_state <= S_DB_GO;
                    end
                end
                S_DB_GO: r_state <= S_DB_WT;
                S_DB_WT: begin
                    if (w_drsp.done) begin
                        r_b     <= w_drsp.value[30:0];
                        r_state <= S_LCM;
                    end
                end
                S_LCM: r_state <= S_T1;
                S_T1: begin
                    r_den   <= r_prod;
                    r_state <= S_T2;
                end
                S_T2: begin
                    r_num   <= r_prod;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_num   <= (r_mode == MODE_SUB) ? r_num - r_prod : r_num + r_prod;
                    r_state <= S_NORM;
                end
                S_P1: r_state <= S_P2;
                S_P2: begin
                    r_num   <= r_prod;
                    r_state <= S_P3;
                end
                S_P3: begin
                    r_den   <= r_prod;
                    r_state <= S_NORM;
                end
                S_NORM: begin
                    if (r_den == '0) begin
                        r_stat  <= ST_ZERO_DEN;
                        r_state <= S_OUT;
                    end else begin
                        if (r_num == '0) begin
                            r_den <= DW'(1);
                        end else if (r_den[DW-1]) begin
                            r_num <= -r_num;
                            r_den <= -r_den;
                        end
                        r_state <= S_G2_GO;
                    end
                end
                S_G2_GO: begin
                    r_neg   <= r_num[DW-1];
                    r_state <= S_G2_WT;
                end
                S_G2_WT: begin
                    if (w_grsp.done) begin
                        r_g     <= w_grsp.value;
                        r_state <= S_DN_GO;
                    end
                end
                S_DN_GO: r_state <= S_DN_WT;
                S_DN_WT: begin
                    if (w_drsp.done) begin
                        r_num   <= r_neg ? -$signed(w_drsp.value) : $signed(w_drsp.value);
                        r_state <= S_DD_GO;
                    end
                end
                S_DD_GO: r_state <= S_DD_WT;
                S_DD_WT: begin
                    if (w_drsp.done) begin
                        r_den   <= $signed(w_drsp.value);
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (r_num < -LIM || r_num > LIM - 1 || r_den > LIM - 1) begin
                        r_stat <= ST_OVERFLOW;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_load) begin
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result register, zeroed on any error
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_rst  <= r_stat;
            r_rnum <= (r_stat == ST_OK) ? r_num[31:0] : '0;
            r_rden <= (r_stat == ST_OK) ? r_den[30:0] : '0;
        end
    end

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_res.valid      = r_ov;
    assign o_res.result_num = r_rnum;
    assign o_res.result_den = r_rden;
    assign o_res.status     = r_rst;
endmodule

### sv/rau_gcd.sv
// binary gcd, one step per cycle
`timescale 1ns / 1ps
module rau_gcd (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rau_pkg::t_unit_req i_req,
    output rau_pkg::t_unit_rsp o_rsp
);
    import rau_pkg::*;

    t_word      r_a, r_b, r_res;
    logic [5:0] r_k;
    logic       r_busy, r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_k    <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_a == '0) begin
                    r_res  <= r_b << r_k;
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else if (r_b == '0) begin
                    r_res  <= r_a << r_k;
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else if (!r_a[0] && !r_b[0]) begin
                    r_a <= r_a >> 1;
                    r_b <= r_b >> 1;
                    r_k <= r_k + 6'd1;
                end else if (!r_a[0]) begin
                    r_a <= r_a >> 1;
                end else if (!r_b[0]) begin
                    r_b <= r_b >> 1;
                end else if (r_a >= r_b) begin
                    r_a <= r_a - r_b;
                end else begin
                    r_b <= r_b - r_a;
                end
            end
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = r_res;
endmodule

### sv/rau_div.sv
// restoring unsigned divider, one quotient bit per cycle
`timescale 1ns / 1ps
module rau_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rau_pkg::t_unit_req i_req,
    output rau_pkg::t_unit_rsp o_rsp
);
    import rau_pkg::*;

    t_word      r_quo, r_dvs;
    logic [DW:0] r_rem;
    logic [5:0] r_cnt;
    logic       r_busy, r_done;
    logic [DW:0] w_sh;
    logic [DW:0] w_diff;

    assign w_sh   = {r_rem[DW-1:0], r_quo[DW-1]};
    assign w_diff = w_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_quo  <= i_req.a;
                r_dvs  <= i_req.b;
                r_rem  <= '0;
                r_cnt  <= '1;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (!w_diff[DW]) begin
                    r_rem <= w_diff;
                    r_quo <= {r_quo[DW-2:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_quo <= {r_quo[DW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = r_quo;
endmodule

### sv/rau_checker.sv
// port-level checks for the rational arithmetic unit, bound to the top level
`timescale 1ns / 1ps
module rau_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_num,
    input logic [30:0] i_den,
    input logic [1:0]  i_status
);
    import rau_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_num) && $stable(i_den)
            && $stable(i_status))
        else $error("result changed while stalled");

    // busy right after taking a request
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready stayed high after a request");

    a_ok_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_OK |-> i_den != '0)
        else $error("ok result with zero denominator");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != ST_OK |-> i_num == '0 && i_den == '0
            && (i_status == ST_ZERO_DEN || i_status == ST_OVERFLOW))
        else $error("error result not cleared");
endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_req.valid),
    .i_in_ready (i_req.ready),
    .i_out_valid(o_res.valid),
    .i_out_ready(o_res.ready),
    .i_num      (o_res.result_num),
    .i_den      (o_res.result_den),
    .i_status   (o_res.status)
);

### sim/tb.sv
// self-checking testbench for the rational arithmetic unit
`timescale 1ns / 1ps
module tb;
    import rau_pkg::*;

    localparam int LIMIT_CYCLES = 5000000;
    localparam int RANDOM_ITEMS = 1300;

    typedef struct {
        logic signed [31:0] num;
        logic [30:0]        den;
        logic [1:0]         status;
    } t_fraction_result;

    typedef struct {
        logic [1:0]         mode;
        logic signed [31:0] n1;
        logic [30:0]        d1;
        logic signed [31:0] n2;
        logic [30:0]        d2;
        logic               typed;
        logic signed [31:0] num;
        logic [30:0]        den;
        logic [1:0]         status;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   cycle_count = 0;
    bit   failed = 1'b0;
    bit   quiet_out = 1'b0;

    rau_req_if req_ch();
    rau_res_if res_ch();

    rational_arithmetic_unit u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_res  (res_ch.source)
    );

    t_fraction_result pending_results[$];

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("rational_arithmetic_unit: mismatch");
            $finish;
        end
    end

    function automatic logic [63:0] euclid_gcd(logic [63:0] x, logic [63:0] y);
        logic [63:0] r;
        while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    function automatic t_fraction_result predict_fraction(logic [1:0] mode,
            logic signed [31:0] n1, logic [30:0] d1,
            logic signed [31:0] n2, logic [30:0] d2);
        t_fraction_result r;
        logic signed [63:0] a1, b1, a2, b2, num, den, lcm, lim;
        logic [63:0] g, mag;
        a1 = n1; a2 = n2;
        b1 = {33'd0, d1}; b2 = {33'd0, d2};
        num = 0; den = 0;
        lim = 64'sd1 <<< (WIDTH - 1);
        r.status = ST_OK;
        if (b1 != 0 && b2 != 0) begin
            case (mode)
                MODE_ADD, MODE_SUB: begin
                    g   = euclid_gcd(b1, b2);
                    lcm = (b1 / $signed(g)) * b2;
                    num = (mode == MODE_ADD) ? a1 * (lcm / b1) + a2 * (lcm / b2)
                                             : a1 * (lcm / b1) - a2 * (lcm / b2);
                    den = lcm;
                end
                MODE_MUL: begin
                    num = a1 * a2;
                    den = b1 * b2;
                end
                default: begin
                    num = a1 * b2;
                    den = b1 * a2;
                end
            endcase
        end
        if (den == 0) begin
            r.status = ST_ZERO_DEN;
        end else begin
            if (num == 0) den = 1;
            if (den < 0) begin
                num = -num;
                den = -den;
            end
            mag = (num < 0) ? -num : num;
            g   = euclid_gcd(mag, den);
            num = num / $signed(g);
            den = den / $signed(g);
            if (num < -lim || num > lim - 1 || den > lim - 1) r.status = ST_OVERFLOW;
        end
        if (r.status != ST_OK) begin
            num = 0;
            den = 0;
        end
        r.num = num[31:0];
        r.den = den[30:0];
        return r;
    endfunction

    // drive one request, waiting for acceptance
    task automatic send_request(t_row row);
        t_fraction_result p;
        if (!quiet_out && $urandom_range(99) < 6) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.mode       <= row.mode;
        req_ch.first_num  <= row.n1;
        req_ch.first_den  <= row.d1;
        req_ch.second_num <= row.n2;
        req_ch.second_den <= row.d2;
        do @(posedge i_clk); while (!req_ch.ready);
        p = predict_fraction(row.mode, row.n1, row.d1, row.n2, row.d2);
        if (row.typed && (p.num != row.num || p.den != row.den || p.status != row.status))
            $display("%0t: table row disagrees with prediction", $time);
        if (row.typed) begin
            p.num = row.num;
            p.den = row.den;
            p.status = row.status;
        end
        pending_results.push_back(p);
        // the block is busy after a request, so valid may stay up until the next drive
        @(negedge i_clk);
    endtask

    // result side: random stalls, compare on acceptance
    always @(negedge i_clk) begin
        if (!i_rst_n)
            res_ch.ready <= 1'b0;
        else
            res_ch.ready <= quiet_out || ($urandom_range(99) >= 6);
    end

    always @(posedge i_clk) begin
        t_fraction_result e;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %0d/%0d st %0d", $time,
                         res_ch.result_num, res_ch.result_den, res_ch.status);
                failed = 1'b1;
            end else begin
                e = pending_results.pop_front();
                if (e.num !== res_ch.result_num || e.den !== res_ch.result_den
                        || e.status !== res_ch.status) begin
                    $display("%0t: expected %0d/%0d st %0d, got %0d/%0d st %0d", $time,
                             e.num, e.den, e.status, res_ch.result_num,
                             res_ch.result_den, res_ch.status);
                    failed = 1'b1;
                end
            end
        end
    end

    function automatic logic signed [31:0] rand_num();
        case ($urandom_range(5))
            0: return $signed($urandom());
            1: return $signed($urandom_range(0, 40)) - 20;
            2: return $signed($urandom_range(0, 2000)) - 1000;
            3: return ($urandom_range(1)) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(0, 200000)) - 100000;
        endcase
    endfunction

    function automatic logic [30:0] rand_den();
        case ($urandom_range(5))
            0: return 31'($urandom());
            1: return 31'($urandom_range(1, 12));
            2: return 31'($urandom_range(1, 1000));
            3: return ($urandom_range(1)) ? 31'h7fffffff : 31'd1;
            4: return ($urandom_range(19) == 0) ? 31'd0 : 31'($urandom_range(1, 100000));
            default: return 31'($urandom_range(1, 100000));
        endcase
    endfunction

    t_row directed[] = '{
        '{MODE_ADD, 32'sd1, 31'd2, 32'sd1, 31'd3, 1'b1, 32'sd5, 31'd6, ST_OK},
        '{MODE_SUB, 32'sd1, 31'd2, 32'sd1, 31'd3, 1'b1, 32'sd1, 31'd6, ST_OK},
        '{MODE_MUL, 32'sd2, 31'd3, 32'sd3, 31'd4, 1'b1, 32'sd1, 31'd2, ST_OK},
        '{MODE_DIV, 32'sd1, 31'd2, 32'sd0, 31'd1, 1'b1, 32'sd0, 31'd0, ST_ZERO_DEN},
        '{MODE_DIV, 32'sd1, 31'd2, -32'sd1, 31'd4, 1'b1, -32'sd2, 31'd1, ST_OK},
        '{MODE_ADD, 32'sd5, 31'd0, 32'sd1, 31'd1, 1'b1, 32'sd0, 31'd0, ST_ZERO_DEN},
        '{MODE_MUL, 32'sd5, 31'd1, 32'sd1, 31'd0, 1'b1, 32'sd0, 31'd0, ST_ZERO_DEN},
        '{MODE_DIV, 32'sd0, 31'd0, 32'sd0, 31'd0, 1'b1, 32'sd0, 31'd0, ST_ZERO_DEN},
        '{MODE_SUB, 32'sd3, 31'd7, 32'sd3, 31'd7, 1'b1, 32'sd0, 31'd1, ST_OK},
        '{MODE_ADD, 32'sh7fffffff, 31'd1, 32'sd1, 31'd1, 1'b1, 32'sd0, 31'd0, ST_OVERFLOW},
        '{MODE_SUB, 32'sh80000000, 31'd1, 32'sd1, 31'd1, 1'b1, 32'sd0, 31'd0, ST_OVERFLOW},
        '{MODE_MUL, 32'sh80000000, 31'd1, -32'sd1, 31'd1, 1'b1, 32'sd0, 31'd0, ST_OVERFLOW},
        '{MODE_DIV, 32'sh80000000, 31'd1, 32'sd1, 31'd1, 1'b1, 32'sh80000000, 31'd1, ST_OK},
        '{MODE_MUL, 32'sd1, 31'h7fffffff, 32'sd1, 31'd2, 1'b1, 32'sd0, 31'd0, ST_OVERFLOW},
        '{MODE_ADD, 32'sh7fffffff, 31'h7fffffff, 32'sh80000000, 31'h7ffffffe, 1'b0, 0, 0, 0},
        '{MODE_DIV, 32'sh7fffffff, 31'h7fffffff, 32'sh80000000, 31'h7fffffff, 1'b0, 0, 0, 0},
        '{MODE_MUL, 32'sh80000000, 31'h7fffffff, 32'sh80000000, 31'h7fffffff, 1'b0, 0, 0, 0},
        '{MODE_SUB, -32'sd1, 31'h7fffffff, 32'sd1, 31'h7ffffffe, 1'b0, 0, 0, 0},
        // unreduced operands still give a reduced result
        '{MODE_ADD, 32'sd2, 31'd4, 32'sd6, 31'd8, 1'b1, 32'sd5, 31'd4, ST_OK},
        '{MODE_MUL, 32'sd4, 31'd6, -32'sd9, 31'd12, 1'b1, -32'sd1, 31'd2, ST_OK},
        '{MODE_DIV, 32'sd0, 31'd5, 32'sd3, 31'd1, 1'b1, 32'sd0, 31'd1, ST_OK},
        '{MODE_ADD, 32'sh55555555, 31'h2aaaaaaa, 32'shaaaaaaaa, 31'h55555555, 1'b0, 0, 0, 0}
    };

    initial begin
        t_row row;
        req_ch.valid = 1'b0;
        req_ch.mode = MODE_ADD;
        req_ch.first_num = '0;
        req_ch.first_den = '0;
        req_ch.second_num = '0;
        req_ch.second_den = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (directed[i]) send_request(directed[i]);
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            quiet_out = (k >= 500 && k < 700);
            row.mode = 2'($urandom_range(3));
            row.n1 = rand_num();
            row.d1 = rand_den();
            row.n2 = rand_num();
            row.d2 = rand_den();
            row.typed = 1'b0;
            row.num = 0; row.den = 0; row.status = ST_OK;
            send_request(row);
        end
        req_ch.valid <= 1'b0;
        quiet_out = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (!failed)
            $display("rational_arithmetic_unit: match");
        else
            $display("rational_arithmetic_unit: mismatch");
        $finish;
    end
endmodule
